// ===== hw/rtl/v3alu_pkg.sv =====
// ----------------------------------------------------------------------------
// v3alu_pkg
// Opcodes, pipeline depths and shared arithmetic helpers of the vector unit.
// ----------------------------------------------------------------------------
package v3alu_pkg;

    typedef enum logic [3:0] {
        MODE_ADD   = 4'd0,
        MODE_SUB   = 4'd1,
        MODE_NEG   = 4'd2,
        MODE_SCALE = 4'd3,
        MODE_DIV   = 4'd4,
        MODE_NORM  = 4'd5,
        MODE_DOT   = 4'd6,
        MODE_CROSS = 4'd7,
        MODE_MAG   = 4'd8,
        MODE_DIST  = 4'd9,
        MODE_EQ    = 4'd10
    } t_mode;

    localparam int SQ_STEPS = 32;
    localparam int DV_STEPS = 48;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [3:0]       mode;
        logic [2:0][31:0] a;
        logic [31:0]      k;
        logic [2:0][31:0] res;
        logic [31:0]      scal;
        logic             eq;
        logic             dz;
    } t_pay;

    function automatic logic [31:0] sat33(input logic [32:0] v);
        logic [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? Q_MIN : Q_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] rnd_sat(input logic [65:0] v);
        logic [65:0] t;
        logic [49:0] h;
        logic [31:0] r;
        t = v + 66'd32768;
        h = t[65:16];
        if ((h[49:31] == '0) || (h[49:31] == '1)) begin
            r = h[31:0];
        end else begin
            r = h[49] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [31:0] quot_sat(input logic [47:0] q, input logic neg);
        logic [31:0] r;
        if (neg) begin
            if ((q[47:32] != '0) || (q[31] && (q[30:0] != '0))) begin
                r = Q_MIN;
            end else begin
                r = 32'd0 - q[31:0];
            end
        end else begin
            r = (q[47:31] != '0) ? Q_MAX : q[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/vector3_alu.sv =====
// ----------------------------------------------------------------------------
// vector3_alu
// Three-component signed Q16.16 vector unit: add, sub, negate, scale, divide,
// normalize, dot, cross, magnitude, distance and equality, all saturating.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the output is not stalled and returns one
// result beat per input beat, in order. Every beat travels the full depth of
// the 32-step square root pipeline (magnitude, distance, normalize) and the
// 48-step restoring divider pipeline with three lanes (divide, normalize).
// A stall on the output holds the whole pipeline.
module vector3_alu
    import v3alu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // mode[3:0], a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, 4 zero bits
    input  logic [231:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // res_x, res_y, res_z, res_scalar, is_equal, div_zero, 6 zero bits
    output logic [135:0] o_m_axis_tdata
);

    logic w_en;

    // stage 1
    logic             r_v1;
    t_pay             r_p1;
    logic [5:0][31:0] r_opa;
    logic [5:0][31:0] r_opb;
    t_pay             n_p1;
    logic [5:0][31:0] n_opa;
    logic [5:0][31:0] n_opb;
    logic [2:0][31:0] n_a;
    logic [2:0][31:0] n_b;
    logic [2:0][31:0] n_dif;

    // stage 2
    logic             r_v2;
    t_pay             r_p2;
    logic [5:0][63:0] r_prod;

    // stage 3
    logic             r_v3;
    t_pay             r_p3;
    logic [2:0][65:0] r_sum;
    logic [2:0][65:0] n_sum;
    logic [5:0][65:0] n_px;

    // square root chain, index 0 is the rounding stage
    logic        r_sq_vld  [0:SQ_STEPS];
    t_pay        r_sq_pay  [0:SQ_STEPS];
    logic [63:0] r_sq_n    [0:SQ_STEPS];
    logic [33:0] r_sq_rem  [0:SQ_STEPS];
    logic [31:0] r_sq_root [0:SQ_STEPS];
    t_pay        n_p4;

    // divider chain, index 0 is the setup stage
    logic             r_dv_vld [0:DV_STEPS];
    t_pay             r_dv_pay [0:DV_STEPS];
    logic [31:0]      r_dv_d   [0:DV_STEPS];
    logic             r_dv_act [0:DV_STEPS];
    logic [2:0]       r_dv_neg [0:DV_STEPS];
    logic [2:0][31:0] r_dv_rem [0:DV_STEPS];
    logic [2:0][47:0] r_dv_q   [0:DV_STEPS];
    t_pay             n_pd;
    logic [31:0]      n_root;
    logic             n_isdiv;

    // output register
    logic r_out_vld;
    t_pay r_out;
    t_pay n_out;

    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {6'd0, r_out.dz, r_out.eq, r_out.scal,
                              r_out.res[2], r_out.res[1], r_out.res[0]};

    // ---- stage 1: unpack, add/sub/negate, equality and divide-by-zero flags, multiplier operand select
    always_comb begin
        n_p1 = '0;
        n_opa = '0;
        n_opb = '0;
        n_p1.mode = i_s_axis_tdata[3:0];
        n_p1.k    = i_s_axis_tdata[196 +: 32];
        for (int i = 0; i < 3; i++) begin
            n_a[i]   = i_s_axis_tdata[4 + 32*i +: 32];
            n_b[i]   = i_s_axis_tdata[100 + 32*i +: 32];
            n_dif[i] = sat33({n_a[i][31], n_a[i]} - {n_b[i][31], n_b[i]});
        end
        n_p1.a = n_a;
        unique case (i_s_axis_tdata[3:0])
            MODE_ADD: begin
                for (int i = 0; i < 3; i++)
                    n_p1.res[i] = sat33({n_a[i][31], n_a[i]} + {n_b[i][31], n_b[i]});
            end
            MODE_SUB: n_p1.res = n_dif;
            MODE_NEG: begin
                for (int i = 0; i < 3; i++)
                    n_p1.res[i] = sat33(33'd0 - {n_a[i][31], n_a[i]});
            end
            MODE_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    n_opa[i] = n_a[i];
                    n_opb[i] = n_p1.k;
                end
            end
            MODE_DIV: n_p1.dz = (n_p1.k == '0);
            MODE_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    n_opa[i] = n_a[i];
                    n_opb[i] = n_b[i];
                end
            end
            MODE_NORM, MODE_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    n_opa[i] = n_a[i];
                    n_opb[i] = n_a[i];
                end
            end
            MODE_DIST: begin
                for (int i = 0; i < 3; i++) begin
                    n_opa[i] = n_dif[i];
                    n_opb[i] = n_dif[i];
                end
            end
            MODE_CROSS: begin
                n_opa[0] = n_a[1]; n_opb[0] = n_b[2];
                n_opa[1] = n_a[2]; n_opb[1] = n_b[0];
                n_opa[2] = n_a[0]; n_opb[2] = n_b[1];
                n_opa[3] = n_a[2]; n_opb[3] = n_b[1];
                n_opa[4] = n_a[0]; n_opb[4] = n_b[2];
                n_opa[5] = n_a[1]; n_opb[5] = n_b[0];
            end
            MODE_EQ: n_p1.eq = (n_a == n_b);
            default: ;
        endcase
    end

    // ---- stage 3 sums of products
    always_comb begin
        n_sum = '0;
        for (int j = 0; j < 6; j++)
            n_px[j] = {{2{r_prod[j][63]}}, r_prod[j]};
        unique case (r_p2.mode)
            MODE_SCALE: begin
                for (int i = 0; i < 3; i++) n_sum[i] = n_px[i];
            end
            MODE_CROSS: begin
                for (int i = 0; i < 3; i++) n_sum[i] = n_px[i] - n_px[i+3];
            end
            MODE_DOT, MODE_NORM, MODE_MAG, MODE_DIST: begin
                n_sum[0] = n_px[0] + n_px[1] + n_px[2];
            end
            default: ;
        endcase
    end

    // ---- stage 4: round and saturate products
    always_comb begin
        n_p4 = r_p3;
        unique case (r_p3.mode)
            MODE_SCALE, MODE_CROSS: begin
                for (int i = 0; i < 3; i++) n_p4.res[i] = rnd_sat(r_sum[i]);
            end
            MODE_DOT: n_p4.scal = rnd_sat(r_sum[0]);
            default: ;
        endcase
    end

    // ---- divider setup from square root result
    always_comb begin
        n_pd    = r_sq_pay[SQ_STEPS];
        n_root  = r_sq_root[SQ_STEPS];
        n_isdiv = (n_pd.mode == MODE_DIV);
        if ((n_pd.mode == MODE_MAG) || (n_pd.mode == MODE_DIST))
            n_pd.scal = n_root[31] ? Q_MAX : n_root;
        if ((n_pd.mode == MODE_NORM) && (n_root == '0))
            n_pd.res = n_pd.a;
    end

    // ---- final sign fix and saturation
    always_comb begin
        n_out = r_dv_pay[DV_STEPS];
        if (r_dv_act[DV_STEPS]) begin
            for (int i = 0; i < 3; i++)
                n_out.res[i] = quot_sat(r_dv_q[DV_STEPS][i], r_dv_neg[DV_STEPS][i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1             <= 1'b0;
            r_v2             <= 1'b0;
            r_v3             <= 1'b0;
            r_sq_vld[0]      <= 1'b0;
            r_dv_vld[0]      <= 1'b0;
            r_out_vld        <= 1'b0;
        end else if (w_en) begin
            r_v1             <= i_s_axis_tvalid;
            r_v2             <= r_v1;
            r_v3             <= r_v2;
            r_sq_vld[0]      <= r_v3;
            r_dv_vld[0]      <= r_sq_vld[SQ_STEPS];
            r_out_vld        <= r_dv_vld[DV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1  <= n_p1;
            r_opa <= n_opa;
            r_opb <= n_opb;
            r_p2  <= r_p1;
            for (int j = 0; j < 6; j++)
                r_prod[j] <= $signed(r_opa[j]) * $signed(r_opb[j]);
            r_p3  <= r_p2;
            r_sum <= n_sum;
            r_sq_pay[0]  <= n_p4;
            r_sq_n[0]    <= r_sum[0][63:0];
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_dv_pay[0]  <= n_pd;
            r_dv_d[0]    <= n_isdiv ? abs32(n_pd.k) : n_root;
            r_dv_act[0]  <= (n_isdiv && (n_pd.k != '0))
                            || ((n_pd.mode == MODE_NORM) && (n_root != '0));
            for (int i = 0; i < 3; i++) begin
                r_dv_neg[0][i] <= n_pd.a[i][31] ^ (n_isdiv & n_pd.k[31]);
                r_dv_q[0][i]   <= {abs32(n_pd.a[i]), 16'd0};
                r_dv_rem[0][i] <= '0;
            end
            r_out <= n_out;
        end
    end

    // ---- square root: two radicand bits per stage
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
        logic [35:0] n_sh;
        logic [35:0] n_trial;
        logic        n_ge;

        assign n_sh    = {r_sq_rem[j], r_sq_n[j][63:62]};
        assign n_trial = {2'b00, r_sq_root[j], 2'b01};
        assign n_ge    = (n_sh >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[j+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_vld[j+1] <= r_sq_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_pay[j+1]  <= r_sq_pay[j];
                r_sq_n[j+1]    <= {r_sq_n[j][61:0], 2'b00};
                r_sq_rem[j+1]  <= n_ge ? 34'(n_sh - n_trial) : n_sh[33:0];
                r_sq_root[j+1] <= {r_sq_root[j][30:0], n_ge};
            end
        end
    end

    // ---- restoring division: one quotient bit per stage in each lane
    for (genvar j = 0; j < DV_STEPS; j++) begin : g_dv
        logic [2:0][32:0] n_sh;
        logic [2:0][32:0] n_diff;
        logic [2:0]       n_ge;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                n_sh[i]   = {r_dv_rem[j][i], r_dv_q[j][i][47]};
                n_diff[i] = n_sh[i] - {1'b0, r_dv_d[j]};
                n_ge[i]   = (n_sh[i] >= {1'b0, r_dv_d[j]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_pay[j+1] <= r_dv_pay[j];
                r_dv_d[j+1]   <= r_dv_d[j];
                r_dv_act[j+1] <= r_dv_act[j];
                r_dv_neg[j+1] <= r_dv_neg[j];
                for (int i = 0; i < 3; i++) begin
                    r_dv_rem[j+1][i] <= n_ge[i] ? n_diff[i][31:0] : n_sh[i][31:0];
                    r_dv_q[j+1][i]   <= {r_dv_q[j][i][46:0], n_ge[i]};
                end
            end
        end
    end

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[0] && r_dv_act[0] |-> r_dv_d[0] != '0)
        else $error("divider started with zero divisor");

    a_dz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.dz |-> (r_out.res == '0) && !r_out.eq && (r_out.scal == '0))
        else $error("divide-by-zero beat carries a nonzero result");

    a_eq_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.eq |-> (r_out.res == '0) && (r_out.scal == '0) && !r_out.dz)
        else $error("equality beat carries a vector or scalar result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_dv_vld[0]) && $stable(r_sq_vld[0]) && $stable(r_v1))
        else $error("pipeline valid moved during a stall");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream-level test of vector3_alu. Directed edge beats, then random beats,
// go through a bursty sender and a stalling receiver. Each accepted beat is
// scored against a bit-accurate Q16.16 prediction, in order.
// ----------------------------------------------------------------------------
module tb;
    import v3alu_pkg::*;

    localparam int N_RANDOM   = 800;
    localparam int IDLE_LIMIT = 5000;
    localparam logic [31:0] ONE_Q = 32'h0001_0000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [231:0] s_data = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [135:0] m_data;

    logic [231:0] pending_beats[$];
    logic [135:0] expected_results[$];
    int errors = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int cycle = 0;
    int idle_cycles = 0;

    vector3_alu dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return Q_MAX;
        if (v < -128'sd2147483648) return Q_MIN;
        return v[31:0];
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] len_q(input longint x, input longint y, input longint z);
        logic [63:0] sq;
        sq = 64'(x * x) + 64'(y * y) + 64'(z * z);
        return root64(sq);
    endfunction

    function automatic logic [31:0] round_q(input logic signed [127:0] v);
        return clamp32((v + 128'sd32768) >>> 16);
    endfunction

    function automatic logic [135:0] vector_result(input logic [231:0] beat);
        logic [3:0] mode;
        longint a[3];
        longint b[3];
        longint d[3];
        longint k;
        longint mm;
        logic [31:0] r[3];
        logic [31:0] s;
        logic eq;
        logic dz;
        logic [63:0] m;
        logic signed [127:0] acc;
        mode = beat[3:0];
        for (int i = 0; i < 3; i++) begin
            a[i] = longint'(signed'(beat[4 + 32*i +: 32]));
            b[i] = longint'(signed'(beat[100 + 32*i +: 32]));
            r[i] = '0;
        end
        k = longint'(signed'(beat[196 +: 32]));
        s = '0;
        eq = 1'b0;
        dz = 1'b0;
        case (mode)
            MODE_ADD: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] + b[i]);
            MODE_SUB: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] - b[i]);
            MODE_NEG: for (int i = 0; i < 3; i++) r[i] = clamp32(-a[i]);
            MODE_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    acc = a[i];
                    r[i] = round_q(acc * k);
                end
            end
            MODE_DIV: begin
                if (k == 0) begin
                    dz = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        acc = a[i];
                        acc = acc * 65536;
                        r[i] = clamp32(acc / k);
                    end
                end
            end
            MODE_NORM: begin
                m = len_q(a[0], a[1], a[2]);
                mm = m;
                for (int i = 0; i < 3; i++) begin
                    if (m == 0) begin
                        r[i] = a[i][31:0];
                    end else begin
                        acc = a[i];
                        acc = acc * 65536;
                        r[i] = clamp32(acc / mm);
                    end
                end
            end
            MODE_DOT: begin
                acc = 0;
                for (int i = 0; i < 3; i++) acc = acc + a[i] * b[i];
                s = round_q(acc);
            end
            MODE_CROSS: begin
                acc = a[1] * b[2];
                r[0] = round_q(acc - a[2] * b[1]);
                acc = a[2] * b[0];
                r[1] = round_q(acc - a[0] * b[2]);
                acc = a[0] * b[1];
                r[2] = round_q(acc - a[1] * b[0]);
            end
            MODE_MAG: begin
                m = len_q(a[0], a[1], a[2]);
                s = (m > 64'(Q_MAX)) ? Q_MAX : m[31:0];
            end
            MODE_DIST: begin
                for (int i = 0; i < 3; i++) d[i] = longint'(signed'(clamp32(a[i] - b[i])));
                m = len_q(d[0], d[1], d[2]);
                s = (m > 64'(Q_MAX)) ? Q_MAX : m[31:0];
            end
            MODE_EQ: eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
            default: ;
        endcase
        return {6'b0, dz, eq, s, r[2], r[1], r[0]};
    endfunction

    function automatic logic [31:0] pick_q();
        case ($urandom_range(0, 7))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return $urandom_range(0, 1) ? ONE_Q : -ONE_Q;
            4, 5: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
            default: return $urandom;
        endcase
    endfunction

    // mode[3:0], a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, 4 zero bits
    function automatic logic [231:0] pack_beat(input logic [3:0] mode,
                                               input logic [31:0] ax, ay, az,
                                               input logic [31:0] bx, by, bz, k);
        return {4'b0, k, bz, by, bx, az, ay, ax, mode};
    endfunction

    initial begin
        logic [3:0] mode;
        logic [31:0] ax, ay, az, bx, by, bz, k;
        for (int md = 0; md < 16; md++) begin
            pending_beats.push_back(pack_beat(4'(md), Q_MAX, Q_MIN, ONE_Q, Q_MAX, Q_MAX, Q_MIN,
                                              Q_MAX));
        end
        pending_beats.push_back(pack_beat(MODE_NEG, Q_MIN, '0, 32'hFFFF_FFFF, '0, '0, '0, '0));
        pending_beats.push_back(pack_beat(MODE_DIV, ONE_Q, Q_MIN, Q_MAX, '0, '0, '0, '0));
        pending_beats.push_back(pack_beat(MODE_DIV, Q_MAX, Q_MIN, 32'd1, '0, '0, '0, 32'd1));
        pending_beats.push_back(pack_beat(MODE_NORM, '0, '0, '0, Q_MAX, '0, '0, '0));
        pending_beats.push_back(pack_beat(MODE_NORM, 32'd1, '0, '0, '0, '0, '0, '0));
        pending_beats.push_back(pack_beat(MODE_EQ, Q_MIN, ONE_Q, Q_MAX, Q_MIN, ONE_Q, Q_MAX, '0));
        pending_beats.push_back(pack_beat(MODE_SCALE, Q_MIN, Q_MIN, 32'h0000_8000, '0, '0, '0,
                                          32'h0000_0001));
        pending_beats.push_back(pack_beat(MODE_MAG, Q_MIN, Q_MIN, Q_MIN, '0, '0, '0, '0));
        pending_beats.push_back(pack_beat(MODE_DIST, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                                          '0));
        for (int n = 0; n < N_RANDOM; n++) begin
            mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                                 : 4'($urandom_range(0, 10));
            ax = pick_q(); ay = pick_q(); az = pick_q();
            bx = pick_q(); by = pick_q(); bz = pick_q();
            k = pick_q();
            if (mode == MODE_EQ && $urandom_range(0, 1)) begin
                bx = ax; by = ay;
                bz = $urandom_range(0, 2) ? az : az ^ (32'd1 << $urandom_range(0, 31));
            end
            pending_beats.push_back(pack_beat(mode, ax, ay, az, bx, by, bz, k));
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_beats.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // sender: bursts of beats separated by gaps, valid held until accepted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!(s_valid && !s_ready)) begin
                if (s_valid) begin
                    expected_results.push_back(vector_result(pending_beats.pop_front()));
                end
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data <= pending_beats[0];
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern chosen by bits 9:8 of the cycle counter, one long hold-off
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (cycle == 300) begin
            hold_left <= 600;
            m_ready <= 1'b0;
        end else begin
            case (cycle[9:8])
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= $urandom_range(0, 1);
                2'd2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        logic [135:0] want;
        if (m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result beat %h", m_data);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (want[31:0] !== m_data[31:0]) begin
                    $error("res_x expected %h actual %h", want[31:0], m_data[31:0]);
                    errors++;
                end
                if (want[63:32] !== m_data[63:32]) begin
                    $error("res_y expected %h actual %h", want[63:32], m_data[63:32]);
                    errors++;
                end
                if (want[95:64] !== m_data[95:64]) begin
                    $error("res_z expected %h actual %h", want[95:64], m_data[95:64]);
                    errors++;
                end
                if (want[127:96] !== m_data[127:96]) begin
                    $error("res_scalar expected %h actual %h", want[127:96], m_data[127:96]);
                    errors++;
                end
                if (want[128] !== m_data[128]) begin
                    $error("is_equal expected %b actual %b", want[128], m_data[128]);
                    errors++;
                end
                if (want[129] !== m_data[129]) begin
                    $error("div_zero expected %b actual %b", want[129], m_data[129]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== sim.f =====
hw/rtl/v3alu_pkg.sv
hw/rtl/vector3_alu.sv
test/tb.sv
